// File: sv/rtp_jpeg_packetizer_assert.svh
// Assertion macros for the packetiser
`ifndef RTP_JPEG_PACKETIZER_ASSERT_SVH
`define RTP_JPEG_PACKETIZER_ASSERT_SVH

// ante holds in a cycle, cons in the same cycle
`define RJP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds in a cycle, cons in the next
`define RJP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rjp_pkg.sv
package rjp_pkg;

    localparam int FRAG_MAX = 1024;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    localparam int CFG_AW = 4;

    localparam logic [1:0] REG_TCP    = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_SSRC   = 2'd3;

    localparam logic        RST_TCP    = 1'b0;
    localparam logic [10:0] RST_WIDTH  = 11'd640;
    localparam logic [10:0] RST_HEIGHT = 11'd480;
    localparam logic [31:0] RST_SSRC   = 32'h13f97e67;

    localparam logic [4:0]  HDR_TCP_LEN    = 5'd24;
    localparam logic [4:0]  HDR_UDP_LEN    = 5'd20;
    localparam logic [4:0]  TCP_PREFIX_LEN = 5'd4;
    localparam logic [15:0] RTP_JPEG_LEN   = 16'd20;

    localparam logic [7:0] HB_DOLLAR  = 8'h24;
    localparam logic [7:0] HB_VERSION = 8'h80;
    localparam logic [6:0] HB_PTYPE   = 7'h1a;
    localparam logic [7:0] HB_QUALITY = 8'h5e;

    localparam logic [31:0] TS_RATE     = 32'd90000;
    localparam logic [31:0] TS_BACKSTEP = 32'd100;
    // floor(x / 125) = (x * DIV_RECIP) >> DIV_SHIFT for any 29-bit x
    localparam logic [29:0] DIV_RECIP   = 30'd549755814;
    localparam int          DIV_SHIFT   = 36;

    typedef struct packed {
        logic [7:0]  data;
        logic        hdr;
        logic        mark;
        logic        plast;
        logic        flast;
        logic [15:0] flen;
        logic [23:0] offset;
        logic [31:0] now_msec;
    } t_entry;

    typedef struct packed {
        logic        tcp;
        logic [10:0] width;
        logic [10:0] height;
        logic [31:0] ssrc;
    } t_cfg;

endpackage

// File: sv/rjp_front.sv
module rjp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [7:0]     i_jpeg_byte,
    input  logic [23:0]    i_frame_bytes,
    input  logic [31:0]    i_now_msec,
    input  logic           i_q_full,
    output logic           o_in_ready,
    output logic           o_push,
    output rjp_pkg::t_entry o_entry
);
    import rjp_pkg::*;

    logic [23:0] r_frame_offset;
    logic [23:0] r_frame_length;
    logic [15:0] r_frag_rem;

    logic        w_hdr;
    logic [23:0] w_len;
    logic [23:0] w_rem;
    logic        w_mark;
    logic [15:0] w_flen;
    logic [15:0] w_frag_left;
    logic [23:0] w_off_next;
    logic        w_flast;

    always_comb begin
        w_hdr       = (r_frag_rem == '0);
        if (r_frame_offset == '0) begin
            w_len = (i_frame_bytes == '0) ? 24'd1 : i_frame_bytes;
        end else begin
            w_len = r_frame_length;
        end
        w_rem       = w_len - r_frame_offset;
        w_mark      = (w_rem <= 24'(FRAG_MAX));
        w_flen      = w_mark ? w_rem[15:0] : 16'(FRAG_MAX);
        w_frag_left = (w_hdr ? w_flen : r_frag_rem) - 16'd1;
        w_off_next  = r_frame_offset + 24'd1;
        w_flast     = (w_off_next == w_len);
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_entry.data     = i_jpeg_byte;
        o_entry.hdr      = w_hdr;
        o_entry.mark     = w_mark;
        o_entry.plast    = (w_frag_left == '0);
        o_entry.flast    = w_flast;
        o_entry.flen     = w_flen;
        o_entry.offset   = r_frame_offset;
        o_entry.now_msec = i_now_msec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_offset <= '0;
            r_frame_length <= '0;
            r_frag_rem     <= '0;
        end else if (o_push) begin
            r_frame_length <= w_len;
            if (w_flast) begin
                r_frame_offset <= '0;
                r_frag_rem     <= '0;
            end else begin
                r_frame_offset <= w_off_next;
                r_frag_rem     <= w_frag_left;
            end
        end
    end

endmodule

// File: sv/rjp_queue.sv
module rjp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rjp_pkg::t_entry i_entry,
    input  logic            i_pop,
    output rjp_pkg::t_entry o_entry,
    output logic            o_valid,
    output logic            o_full
);
    import rjp_pkg::*;

    t_entry           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QCW-1:0]   r_count;

    assign o_entry = r_mem[r_rp];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCW'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: sv/rjp_back.sv
module rjp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rjp_pkg::t_cfg   i_cfg,
    input  rjp_pkg::t_entry i_entry,
    input  logic            i_q_valid,
    output logic            o_pop,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_packet_start,
    output logic            o_packet_last,
    output logic            o_frame_last,
    output logic            o_is_payload
);
    import rjp_pkg::*;

    logic        r_ov;
    logic [7:0]  r_byte;
    logic        r_ps;
    logic        r_pl;
    logic        r_fl;
    logic        r_pay;
    logic [4:0]  r_cnt;
    logic [15:0] r_seq;
    logic [31:0] r_ts;
    logic [31:0] r_prev;
    logic        r_mul_v;
    logic        r_div_v;
    logic [31:0] r_prod;
    logic [22:0] r_quot;

    logic        w_load;
    logic        w_go;
    logic        w_in_hdr;
    logic [4:0]  w_hdr_len;
    logic [4:0]  w_idx;
    logic [15:0] w_size;
    logic [7:0]  w_hb;
    logic [31:0] w_delta;
    logic [58:0] w_div_full;

    always_comb begin
        w_load    = !r_ov || i_out_ready;
        w_hdr_len = i_cfg.tcp ? HDR_TCP_LEN : HDR_UDP_LEN;
        w_in_hdr  = i_entry.hdr && (r_cnt != w_hdr_len);
        w_go      = w_load && i_q_valid && !r_mul_v && !r_div_v;
        o_pop     = w_go && !w_in_hdr;
        w_idx     = r_cnt + (i_cfg.tcp ? 5'd0 : TCP_PREFIX_LEN);
        w_size    = i_entry.flen + RTP_JPEG_LEN;
        w_delta   = (i_entry.now_msec >= r_prev) ? (i_entry.now_msec - r_prev) : TS_BACKSTEP;
        w_div_full = 59'(r_prod[31:3]) * 59'(DIV_RECIP);
    end

    always_comb begin
        case (w_idx)
            5'd0:    w_hb = HB_DOLLAR;
            5'd1:    w_hb = 8'h00;
            5'd2:    w_hb = w_size[15:8];
            5'd3:    w_hb = w_size[7:0];
            5'd4:    w_hb = HB_VERSION;
            5'd5:    w_hb = {i_entry.mark, HB_PTYPE};
            5'd6:    w_hb = r_seq[15:8];
            5'd7:    w_hb = r_seq[7:0];
            5'd8:    w_hb = r_ts[31:24];
            5'd9:    w_hb = r_ts[23:16];
            5'd10:   w_hb = r_ts[15:8];
            5'd11:   w_hb = r_ts[7:0];
            5'd12:   w_hb = i_cfg.ssrc[31:24];
            5'd13:   w_hb = i_cfg.ssrc[23:16];
            5'd14:   w_hb = i_cfg.ssrc[15:8];
            5'd15:   w_hb = i_cfg.ssrc[7:0];
            5'd16:   w_hb = 8'h00;
            5'd17:   w_hb = i_entry.offset[23:16];
            5'd18:   w_hb = i_entry.offset[15:8];
            5'd19:   w_hb = i_entry.offset[7:0];
            5'd20:   w_hb = 8'h00;
            5'd21:   w_hb = HB_QUALITY;
            5'd22:   w_hb = i_cfg.width[10:3];
            5'd23:   w_hb = i_cfg.height[10:3];
            default: w_hb = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_byte <= w_in_hdr ? w_hb : i_entry.data;
            r_ps   <= w_in_hdr && (r_cnt == '0);
            r_pl   <= !w_in_hdr && i_entry.plast;
            r_fl   <= !w_in_hdr && i_entry.flast;
            r_pay  <= !w_in_hdr;
        end
        if (o_pop && i_entry.flast) begin
            r_prod <= w_delta * TS_RATE;
        end
        if (r_mul_v) begin
            r_quot <= w_div_full[58:DIV_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_cnt   <= '0;
            r_seq   <= '0;
            r_ts    <= '0;
            r_prev  <= '0;
            r_mul_v <= 1'b0;
            r_div_v <= 1'b0;
        end else begin
            if (w_go) begin
                r_ov  <= 1'b1;
                r_cnt <= w_in_hdr ? (r_cnt + 5'd1) : 5'd0;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (o_pop && i_entry.hdr) begin
                r_seq <= r_seq + 16'd1;
            end
            if (o_pop && i_entry.flast) begin
                r_prev <= i_entry.now_msec;
            end
            r_mul_v <= o_pop && i_entry.flast;
            r_div_v <= r_mul_v;
            if (r_div_v) begin
                r_ts <= r_ts + 32'(r_quot);
            end
        end
    end

    assign o_out_valid    = r_ov;
    assign o_out_byte     = r_byte;
    assign o_packet_start = r_ps;
    assign o_packet_last  = r_pl;
    assign o_frame_last   = r_fl;
    assign o_is_payload   = r_pay;

endmodule

// File: sv/rtp_jpeg_packetizer.sv
// RTP/JPEG packetiser: cuts JPEG frames into RTP packets of at most 1024 data bytes.
// Input channel: one frame byte per item (i_in_valid / o_in_ready), with the frame
// length sampled on a frame's first byte and the millisecond clock on its last.
// Output channel: one packet-stream byte per item (o_out_valid / i_out_ready) with
// packet start, packet end, frame end and payload flags.
// Each input item yields its data byte, preceded by a 20-byte header (24 with the
// TCP interleave prefix) when it opens a fragment.
// A data byte is written into the queue and then into the output byte register; when it
// opens a fragment, its header bytes go out first, one after another.
// Throughput: one byte per cycle on the output while the receiver is ready, so one
// item per cycle inside a fragment; the output byte register limits it. After a
// frame's last byte the timestamp unit (multiply, then reciprocal divide by 1000)
// holds the next header until the timestamp update is done.
// A four-entry queue between the classifier and the byte serialiser keeps input
// flowing while the output stalls; the input stalls only once the queue is full.
// Reset (synchronous, active low) clears the packet state and loads the register
// defaults; nothing is lost when the receiver stalls, the output byte is held.
// Registers: 0 tcp_interleaved, 1 image_width, 2 image_height, 3 ssrc, at 4*i.
`include "rtp_jpeg_packetizer_assert.svh"

module rtp_jpeg_packetizer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_jpeg_byte,
    input  logic [23:0]                i_frame_bytes,
    input  logic [31:0]                i_now_msec,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [7:0]                 o_out_byte,
    output logic                       o_packet_start,
    output logic                       o_packet_last,
    output logic                       o_frame_last,
    output logic                       o_is_payload,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rjp_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import rjp_pkg::*;

    t_cfg   r_cfg;
    t_entry w_push_entry;
    t_entry w_head;
    logic   w_push;
    logic   w_pop;
    logic   w_q_valid;
    logic   w_q_full;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tcp    <= RST_TCP;
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
            r_cfg.ssrc   <= RST_SSRC;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_TCP:    r_cfg.tcp    <= pwdata[0];
                REG_WIDTH:  r_cfg.width  <= pwdata[10:0];
                REG_HEIGHT: r_cfg.height <= pwdata[10:0];
                REG_SSRC:   r_cfg.ssrc   <= pwdata;
                default:    r_cfg.ssrc   <= r_cfg.ssrc;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TCP:    prdata = {31'd0, r_cfg.tcp};
            REG_WIDTH:  prdata = {21'd0, r_cfg.width};
            REG_HEIGHT: prdata = {21'd0, r_cfg.height};
            REG_SSRC:   prdata = r_cfg.ssrc;
            default:    prdata = '0;
        endcase
    end

    rjp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_jpeg_byte   (i_jpeg_byte),
        .i_frame_bytes (i_frame_bytes),
        .i_now_msec    (i_now_msec),
        .i_q_full      (w_q_full),
        .o_in_ready    (o_in_ready),
        .o_push        (w_push),
        .o_entry       (w_push_entry)
    );

    rjp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head),
        .o_valid (w_q_valid),
        .o_full  (w_q_full)
    );

    rjp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_entry        (w_head),
        .i_q_valid      (w_q_valid),
        .o_pop          (w_pop),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_packet_start (o_packet_start),
        .o_packet_last  (o_packet_last),
        .o_frame_last   (o_frame_last),
        .o_is_payload   (o_is_payload)
    );

    `RJP_ASSERT_SAME(a_frame_end_flags, i_clk, i_rst_n,
        o_out_valid && o_frame_last, o_packet_last && o_is_payload,
        "frame end without packet end on a data byte")
    `RJP_ASSERT_SAME(a_packet_start_byte, i_clk, i_rst_n,
        o_out_valid && o_packet_start,
        !o_is_payload && (o_out_byte == HB_DOLLAR || o_out_byte == HB_VERSION),
        "packet start on an unexpected byte")
    `RJP_ASSERT_NEXT(a_ts_holds_next, i_clk, i_rst_n,
        w_pop && w_head.flast, !w_pop,
        "item taken while the timestamp update is in flight")

endmodule

// File: tb/rtp_jpeg_packetizer_tb.sv
`timescale 1ns / 100ps

module rtp_jpeg_packetizer_tb;

    import rjp_pkg::*;

    localparam int SHOW_MAX  = 10;
    localparam int HOLD_CYC  = 300;
    localparam int PHASE_MIN = 50;

    localparam logic [7:0]  PFX_DOLLAR = 8'h24;
    localparam logic [7:0]  RTP_VER    = 8'h80;
    localparam logic [7:0]  RTP_PT     = 8'h1a;
    localparam logic [7:0]  JPEG_QUAL  = 8'h5e;
    localparam logic [31:0] CLK_RATE   = 32'd90000;
    localparam logic [31:0] MSEC_DIV   = 32'd1000;
    localparam logic [31:0] BACK_DELTA = 32'd100;

    typedef struct {
        logic [7:0]  jpeg_byte;
        logic [23:0] frame_bytes;
        logic [31:0] now_msec;
    } t_frame_item;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       plast;
        logic       flast;
        logic       payload;
    } t_stream_byte;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [7:0]        i_jpeg_byte = '0;
    logic [23:0]       i_frame_bytes = '0;
    logic [31:0]       i_now_msec = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [7:0]        o_out_byte;
    logic              o_packet_start;
    logic              o_packet_last;
    logic              o_frame_last;
    logic              o_is_payload;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    t_frame_item  pending_items[$];
    t_stream_byte packet_stream[$];
    t_frame_item  next_item;
    t_stream_byte stream_head;

    logic        cfg_tcp = RST_TCP;
    logic [10:0] cfg_width = RST_WIDTH;
    logic [10:0] cfg_height = RST_HEIGHT;
    logic [31:0] cfg_ssrc = RST_SSRC;

    logic [23:0] frame_pos = '0;
    logic [23:0] frame_len = '0;
    logic [15:0] frag_left = '0;
    logic [15:0] seq_num = '0;
    logic [31:0] rtp_ts = '0;
    logic [31:0] last_end_msec = '0;

    logic [31:0] wall_msec = '0;
    logic        in_fire = 1'b0;
    logic        long_hold = 1'b0;
    logic        rx_bit;
    int          rx_mode = 0;
    int          rx_span = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          items_taken = 0;
    int          mismatches = 0;

    rtp_jpeg_packetizer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_jpeg_byte    (i_jpeg_byte),
        .i_frame_bytes  (i_frame_bytes),
        .i_now_msec     (i_now_msec),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_packet_start (o_packet_start),
        .o_packet_last  (o_packet_last),
        .o_frame_last   (o_frame_last),
        .o_is_payload   (o_is_payload),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #24_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic packetise_item(input logic [7:0] jbyte, input logic [23:0] fbytes,
                                  input logic [31:0] now);
        logic [7:0]  hdr [0:23];
        logic [23:0] rem;
        logic [15:0] flen;
        logic [15:0] pkt_len;
        logic        last_frag;
        logic [31:0] delta;
        logic [63:0] wide;
        int          first;
        if (frag_left == 0) begin
            if (frame_pos == 0) begin
                frame_len = (fbytes == 0) ? 24'd1 : fbytes;
            end
            rem       = frame_len - frame_pos;
            flen      = (rem > FRAG_MAX) ? 16'(FRAG_MAX) : rem[15:0];
            last_frag = (24'(flen) == rem);
            pkt_len   = flen + 16'd20;
            hdr[0]  = PFX_DOLLAR;
            hdr[1]  = 8'h00;
            hdr[2]  = pkt_len[15:8];
            hdr[3]  = pkt_len[7:0];
            hdr[4]  = RTP_VER;
            hdr[5]  = RTP_PT | {last_frag, 7'b0};
            hdr[6]  = seq_num[15:8];
            hdr[7]  = seq_num[7:0];
            hdr[8]  = rtp_ts[31:24];
            hdr[9]  = rtp_ts[23:16];
            hdr[10] = rtp_ts[15:8];
            hdr[11] = rtp_ts[7:0];
            hdr[12] = cfg_ssrc[31:24];
            hdr[13] = cfg_ssrc[23:16];
            hdr[14] = cfg_ssrc[15:8];
            hdr[15] = cfg_ssrc[7:0];
            hdr[16] = 8'h00;
            hdr[17] = frame_pos[23:16];
            hdr[18] = frame_pos[15:8];
            hdr[19] = frame_pos[7:0];
            hdr[20] = 8'h00;
            hdr[21] = JPEG_QUAL;
            hdr[22] = cfg_width[10:3];
            hdr[23] = cfg_height[10:3];
            first = cfg_tcp ? 0 : 4;
            for (int i = first; i < 24; i++) begin
                packet_stream.push_back('{hdr[i], i == first, 1'b0, 1'b0, 1'b0});
            end
            seq_num   = seq_num + 16'd1;
            frag_left = flen;
        end
        frag_left = frag_left - 16'd1;
        frame_pos = frame_pos + 24'd1;
        packet_stream.push_back('{jbyte, 1'b0, frag_left == 0, frame_pos == frame_len, 1'b1});
        if (frame_pos == frame_len) begin
            delta         = (now >= last_end_msec) ? now - last_end_msec : BACK_DELTA;
            wide          = 64'(CLK_RATE) * 64'(delta);
            last_end_msec = now;
            rtp_ts        = rtp_ts + wide[31:0] / MSEC_DIV;
            frame_pos     = '0;
            frag_left     = '0;
        end
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= SHOW_MAX) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (packet_stream.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX) begin
                        $display("%0t: unexpected output byte %0h", $time, o_out_byte);
                    end
                end else begin
                    stream_head = packet_stream.pop_front();
                    check_field("out_byte", stream_head.data, o_out_byte);
                    check_field("packet_start", 8'(stream_head.start), 8'(o_packet_start));
                    check_field("packet_last", 8'(stream_head.plast), 8'(o_packet_last));
                    check_field("frame_last", 8'(stream_head.flast), 8'(o_frame_last));
                    check_field("is_payload", 8'(stream_head.payload), 8'(o_is_payload));
                end
            end
            if (i_in_valid && o_in_ready) begin
                packetise_item(i_jpeg_byte, i_frame_bytes, i_now_msec);
                items_taken <= items_taken + 1;
            end
        end
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (gap_left > 0 || pending_items.size() == 0) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end
                i_in_valid <= 1'b0;
            end else begin
                next_item = pending_items.pop_front();
                i_jpeg_byte   <= next_item.jpeg_byte;
                i_frame_bytes <= next_item.frame_bytes;
                i_now_msec    <= next_item.now_msec;
                i_in_valid    <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_span <= $urandom_range(8, 80);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            0: rx_bit = 1'b1;
            1: rx_bit = 1'($urandom_range(0, 1));
            2: rx_bit = ($urandom_range(0, 3) == 0);
            default: rx_bit = (rx_span % 5 != 0);
        endcase
        i_out_ready <= !long_hold && rx_bit;
    end

    // starve the output while the sender keeps offering items
    initial begin
        wait (items_taken >= 40);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_TCP:    cfg_tcp = value[0];
            REG_WIDTH:  cfg_width = value[10:0];
            REG_HEIGHT: cfg_height = value[10:0];
            REG_SSRC:   cfg_ssrc = value;
            default:    ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || packet_stream.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_item(input logic [7:0] jbyte, input logic [23:0] fbytes,
                             input logic [31:0] now);
        pending_items.push_back('{jbyte, fbytes, now});
    endtask

    task automatic queue_frame(input int len, input logic [23:0] first_bytes,
                               input logic [31:0] end_msec);
        for (int i = 0; i < len; i++) begin
            push_item(8'($urandom), (i == 0) ? first_bytes : 24'($urandom),
                      (i == len - 1) ? end_msec : $urandom);
        end
    endtask

    function automatic logic [31:0] advance_clock();
        case ($urandom_range(0, 9))
            0: wall_msec = wall_msec - $urandom_range(1, 5000);
            1: wall_msec = wall_msec + $urandom_range(47722, 200000);
            2: wall_msec = $urandom;
            default: wall_msec = wall_msec + $urandom_range(0, 400);
        endcase
        return wall_msec;
    endfunction

    function automatic logic [31:0] pick_dim();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'd2040;
            2: return $urandom_range(0, 15);
            default: return $urandom_range(0, 2040);
        endcase
    endfunction

    initial begin
        int len;
        int queued;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: zero length, ignored mid-frame length, clock behind
        push_item(8'h00, 24'd0, 32'd0);
        push_item(8'hFF, 24'd3, $urandom);
        push_item(8'hA5, 24'hFFFFFF, 32'd0);
        push_item(8'h5A, 24'd0, 32'hFFFFFFFF);
        push_item(8'h3C, 24'd1, 32'd5);
        queue_frame(2, 24'd2, 32'd47727);
        wait_drained();

        write_reg(REG_TCP, 32'd1);
        write_reg(REG_WIDTH, 32'd2040);
        write_reg(REG_HEIGHT, 32'd0);
        write_reg(REG_SSRC, 32'hFFFFFFFF);
        queue_frame(4, 24'd4, 32'd47730);
        queue_frame(1, 24'd1, 32'd47730);
        wait_drained();

        write_reg(REG_TCP, 32'd0);
        write_reg(REG_WIDTH, 32'd0);
        write_reg(REG_HEIGHT, 32'd2040);
        write_reg(REG_SSRC, 32'd0);
        queue_frame(5, 24'd5, 32'd47731);
        wait_drained();
        wall_msec = 32'd47731;

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_TCP, ph % 2);
            write_reg(REG_WIDTH, pick_dim());
            write_reg(REG_HEIGHT, pick_dim());
            case ($urandom_range(0, 2))
                0: write_reg(REG_SSRC, 32'd0);
                1: write_reg(REG_SSRC, 32'hFFFFFFFF);
                default: write_reg(REG_SSRC, $urandom);
            endcase
            queued = 0;
            while (queued < PHASE_MIN) begin
                len = ($urandom_range(0, 6) == 0) ? 1 : $urandom_range(1, 30);
                queue_frame(len, (len == 1 && $urandom_range(0, 1)) ? 24'd0 : 24'(len),
                            advance_clock());
                queued += len;
            end
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && packet_stream.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
